// ===== rtl/scc_pkg.sv =====
package scc_pkg;

	localparam int COORD_W = 16;
	localparam int FRAC_W  = 24;
	localparam int TOL_W   = 16;

	// Class codes
	localparam logic [1:0] CLS_APART = 2'd0;
	localparam logic [1:0] CLS_CROSS = 2'd1;
	localparam logic [1:0] CLS_DEGEN = 2'd2;

	localparam logic [TOL_W-1:0] TOL_RESET = 16'd429;

	// Differences of two coordinates: 17 bits; products of two: 34 bits;
	// difference of two products: 35 bits.
	localparam int DIF_W  = COORD_W + 1;
	localparam int PRD_W  = 2 * DIF_W;
	localparam int SUM_W  = PRD_W + 1;
	// Tolerance times a magnitude, and the scaled compare width.
	localparam int TPR_W  = SUM_W + TOL_W + 1;
	localparam int CMP_W  = SUM_W + 34;

	// Divider cell payload: remainder and denominator, both nonnegative.
	typedef struct packed {
		logic              vld;
		logic [1:0]        cls;
		logic [SUM_W-1:0]  den;
		logic [SUM_W-1:0]  rem_a;
		logic [SUM_W-1:0]  rem_b;
		logic [FRAC_W-1:0] q_a;
		logic [FRAC_W-1:0] q_b;
	} div_cell_t;

endpackage

// ===== rtl/scc_div_cell.sv =====
module scc_div_cell
	import scc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  div_cell_t d_in,
	output div_cell_t d_out
);

	logic [SUM_W:0] ra_2, rb_2, den_x;
	logic           ge_a, ge_b;
	div_cell_t      nxt;
	div_cell_t      cell_q;

	always_comb begin
		den_x = {1'b0, d_in.den};
		ra_2  = {d_in.rem_a, 1'b0};
		rb_2  = {d_in.rem_b, 1'b0};
		ge_a  = ra_2 >= den_x;
		ge_b  = rb_2 >= den_x;
		nxt   = d_in;
		nxt.rem_a = ge_a ? SUM_W'(ra_2 - den_x) : ra_2[SUM_W-1:0];
		nxt.rem_b = ge_b ? SUM_W'(rb_2 - den_x) : rb_2[SUM_W-1:0];
		nxt.q_a   = {d_in.q_a[FRAC_W-2:0], ge_a};
		nxt.q_b   = {d_in.q_b[FRAC_W-2:0], ge_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (adv) begin
			cell_q <= nxt;
		end
	end

	assign d_out = cell_q;

endmodule

// ===== rtl/segment_crossing_classifier_top.sv =====
// Channel | Dir | Payload
// s_axis  | in  | tdata[127:0]: eight 16-bit coords, first_start_x lowest
// m_axis  | out | tdata[55:0]: pair_class, first_fraction, second_fraction
// cfg     | in  | cfg_data[15:0]: end_tolerance
//
// Pipeline: 3 front stages plus 24 divider cells; one pair per cycle while m_axis is not stalled.
// The row of restoring-divider cells, one quotient bit per cell, sets the latency.
// Reset clears all valid bits and loads end_tolerance with 429.
// A stall on m_axis freezes the whole pipeline; the output register holds.
module segment_crossing_classifier_top
	import scc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // fsx,fsy,fex,fey,gsx,gsy,gex,gey
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [55:0]  m_axis_tdata,   // [1:0] pair_class, [25:2] first_fraction,
	                                     // [49:26] second_fraction, zeros above
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	logic [TOL_W-1:0] tol_q;
	logic             adv;

	// Pipeline advances whenever the output slot is free or being taken.
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// Stage 1: differences.
	logic signed [DIF_W-1:0] dsx, dsy, dcx, dcy, tx, ty, ux, uy;
	logic signed [DIF_W-1:0] dsx_s1, dsy_s1, dcx_s1, dcy_s1, tx_s1, ty_s1, ux_s1, uy_s1;
	logic                    vld_s1;

	function automatic logic signed [DIF_W-1:0] sub(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		sub = DIF_W'($signed(a)) - DIF_W'($signed(b));
	endfunction

	always_comb begin
		dsx = sub(s_axis_tdata[47:32],   s_axis_tdata[15:0]);
		dsy = sub(s_axis_tdata[63:48],   s_axis_tdata[31:16]);
		dcx = sub(s_axis_tdata[111:96],  s_axis_tdata[79:64]);
		dcy = sub(s_axis_tdata[127:112], s_axis_tdata[95:80]);
		tx  = sub(s_axis_tdata[79:64],   s_axis_tdata[15:0]);
		ty  = sub(s_axis_tdata[95:80],   s_axis_tdata[31:16]);
		ux  = sub(s_axis_tdata[111:96],  s_axis_tdata[15:0]);
		uy  = sub(s_axis_tdata[127:112], s_axis_tdata[31:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dsx_s1 <= dsx; dsy_s1 <= dsy; dcx_s1 <= dcx; dcy_s1 <= dcy;
			tx_s1  <= tx;  ty_s1  <= ty;  ux_s1  <= ux;  uy_s1  <= uy;
		end
	end

	// Stage 2: cross and dot products.
	logic signed [SUM_W-1:0] d_s2, na_s2, nb_s2, len_s2, p0_s2, p1_s2;
	logic                    vld_s2;

	function automatic logic signed [SUM_W-1:0] x2(input logic signed [DIF_W-1:0] a,
		input logic signed [DIF_W-1:0] b, input logic signed [DIF_W-1:0] c,
		input logic signed [DIF_W-1:0] e, input logic neg);
		logic signed [SUM_W-1:0] p, q;
		p = SUM_W'(a * b);
		q = SUM_W'(c * e);
		x2 = neg ? p - q : p + q;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2   <= x2(dsx_s1, dcy_s1, dsy_s1, dcx_s1, 1'b1);
			na_s2  <= x2(tx_s1, dcy_s1, ty_s1, dcx_s1, 1'b1);
			nb_s2  <= x2(tx_s1, dsy_s1, ty_s1, dsx_s1, 1'b1);
			len_s2 <= x2(dsx_s1, dsx_s1, dsy_s1, dsy_s1, 1'b0);
			p0_s2  <= x2(tx_s1, dsx_s1, ty_s1, dsy_s1, 1'b0);
			p1_s2  <= x2(ux_s1, dsx_s1, uy_s1, dsy_s1, 1'b0);
		end
	end

	// Stage 3: normalize sign and classify. Compare x*2^32 against t*m.
	logic signed [SUM_W-1:0] ad, an_a, an_b, hi, lo, base;
	logic signed [TPR_W-1:0] tm;
	logic                    par;
	logic [1:0]              cls;
	div_cell_t               c0;
	div_cell_t               c0_s3;

	// -1, 0, +1 of x*2^32 - y
	function automatic logic signed [1:0] cmps(input logic signed [SUM_W-1:0] x,
		input logic signed [TPR_W-1:0] y);
		logic signed [CMP_W-1:0] p, q;
		p = CMP_W'(x) <<< 32;
		q = CMP_W'(y);
		cmps = (p < q) ? -2'sd1 : ((p > q) ? 2'sd1 : 2'sd0);
	endfunction

	always_comb begin
		par  = (d_s2 == '0);
		ad   = d_s2[SUM_W-1] ? -d_s2 : d_s2;
		an_a = d_s2[SUM_W-1] ? -na_s2 : na_s2;
		an_b = d_s2[SUM_W-1] ? -nb_s2 : nb_s2;
		hi   = (p0_s2 > p1_s2) ? p0_s2 : p1_s2;
		lo   = (p0_s2 > p1_s2) ? p1_s2 : p0_s2;
		base = par ? len_s2 : ad;
		tm   = TPR_W'($signed({1'b0, tol_q})) * TPR_W'(base);
		cls  = CLS_APART;
		if (par) begin
			if (nb_s2 == '0 && len_s2 > 0 &&
					cmps(hi, tm) > 0 && cmps(lo - len_s2, -tm) < 0)
				cls = CLS_DEGEN;
		end else if (cmps(an_a, -tm) < 0 || cmps(an_a - ad, tm) > 0 ||
				cmps(an_b, -tm) < 0 || cmps(an_b - ad, tm) > 0) begin
			cls = CLS_APART;
		end else if (cmps(an_a, tm) <= 0 || cmps(an_a - ad, -tm) >= 0 ||
				cmps(an_b, tm) <= 0 || cmps(an_b - ad, -tm) >= 0) begin
			cls = CLS_DEGEN;
		end else begin
			cls = CLS_CROSS;
		end
		c0.vld   = vld_s2;
		c0.cls   = cls;
		c0.den   = (cls == CLS_CROSS) ? ad : SUM_W'(1);
		c0.rem_a = (cls == CLS_CROSS) ? an_a : '0;
		c0.rem_b = (cls == CLS_CROSS) ? an_b : '0;
		c0.q_a   = '0;
		c0.q_b   = '0;
	end

	// Hold the stage-3 result in its own register ahead of the divider row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_s3 <= '0;
		end else if (adv) begin
			c0_s3 <= c0;
		end
	end

	// Chain of divider cells, one quotient bit per cell.
	div_cell_t chain [FRAC_W+1];
	assign chain[0] = c0_s3;

	for (genvar i = 0; i < FRAC_W; i++) begin : g_cell
		scc_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.d_in  (chain[i]),
			.d_out (chain[i+1])
		);
	end

	assign m_axis_tvalid = chain[FRAC_W].vld;
	assign m_axis_tdata  = {6'b0, chain[FRAC_W].q_b, chain[FRAC_W].q_a, chain[FRAC_W].cls};

	// Class never takes the unused code.
	a_cls: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] <= CLS_DEGEN)
		else $error("bad class");
	// Fractions are zero outside a clean crossing.
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != CLS_CROSS) |-> m_axis_tdata[49:2] == '0)
		else $error("fraction outside crossing");
	// A stalled output holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output moved under stall");

endmodule
